### sv/ilir_pkg.sv
// ilir_pkg: shared widths, operation and status codes, and the command struct
// used between the controller and the datapath of the indexed list unit
// depends on nothing
package ilir_pkg;

  localparam int OP_W     = 2;
  localparam int POS_W    = 4;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // operation codes carried in the input tuser
  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // capacity after reset
  localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // output slot of the result register
  typedef enum logic {
    SLOT_EMPTY,
    SLOT_HELD
  } slot_state_t;

  // command from controller to datapath for the item accepted this cycle
  typedef struct packed {
    logic    load;     // capture a result into the output register
    logic    ins;      // insert word at position, shift upper entries up
    logic    rem;      // remove entry at position, shift upper entries down
    logic    rd_en;    // read entry at position into the result
    status_t status;
  } cmd_t;

endpackage

### sv/ilir_ctrl.sv
// ilir_ctrl: handshake control, output slot state machine, capacity register
// and per-item decision (status and shift command)
// depends on ilir_pkg
module ilir_ctrl
  import ilir_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [POS_W-1:0]    position,
  input  logic [COUNT_W-1:0]  count,
  output logic                out_valid,
  input  logic                out_ready,
  output cmd_t                cmd
);

  slot_state_t        state;
  slot_state_t        state_next;
  logic [COUNT_W-1:0] max_count;
  logic               accept;
  logic               is_full;
  int                 pos_i;
  int                 cnt_i;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_COUNT_RESET;
    end else if (cfg_we) begin
      max_count <= cfg_wdata;
    end
  end

  // output slot state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SLOT_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // handshake and next slot state
  always_comb begin
    in_ready  = (state == SLOT_EMPTY) || out_ready;
    out_valid = (state == SLOT_HELD);
    accept    = in_valid && in_ready;
    unique case (state)
      SLOT_EMPTY: state_next = accept ? SLOT_HELD : SLOT_EMPTY;
      SLOT_HELD: begin
        if (accept) begin
          state_next = SLOT_HELD;
        end else if (out_ready) begin
          state_next = SLOT_EMPTY;
        end else begin
          state_next = SLOT_HELD;
        end
      end
      default: state_next = SLOT_EMPTY;
    endcase
  end

  // per-item decision, capacity clamped to the built depth
  always_comb begin
    pos_i   = int'(position);
    cnt_i   = int'(count);
    is_full = (count >= max_count) || (cnt_i >= DEPTH);
    cmd        = '0;
    cmd.load   = accept;
    cmd.status = ST_OK;
    unique case (op)
      OP_GET: begin
        if (pos_i < cnt_i) begin
          cmd.rd_en = accept;
        end else begin
          cmd.status = ST_RANGE;
        end
      end
      OP_INSERT: begin
        if (pos_i > cnt_i) begin
          cmd.status = ST_RANGE;
        end else if (is_full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.ins = accept;
        end
      end
      OP_REMOVE: begin
        if (pos_i < cnt_i) begin
          cmd.rem = accept;
        end else begin
          cmd.status = ST_RANGE;
        end
      end
      default: cmd.status = ST_RANGE;
    endcase
  end

endmodule

### sv/ilir_datapath.sv
// ilir_datapath: row of entry registers that shift per cell, entry counter,
// read selector and the output result register
// depends on ilir_pkg
module ilir_datapath
  import ilir_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic [POS_W-1:0]          position,
  input  logic signed [DATA_W-1:0]  data,
  output logic [COUNT_W-1:0]        count,
  output status_t                   out_status,
  output logic signed [DATA_W-1:0]  out_read_data,
  output logic [COUNT_W-1:0]        out_count
);

  logic signed [DATA_W-1:0] entries [DEPTH];
  logic signed [DATA_W-1:0] below   [DEPTH];
  logic signed [DATA_W-1:0] above   [DEPTH];
  logic signed [DATA_W-1:0] rd_word;
  logic [COUNT_W-1:0]       count_next;
  int                       pos_i;
  int                       cnt_i;

  assign pos_i = int'(position);
  assign cnt_i = int'(count);

  // neighbor taps for every cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_lo
      assign below[i] = '0;
    end else begin : g_lo_n
      assign below[i] = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign above[i] = '0;
    end else begin : g_hi_n
      assign above[i] = entries[i+1];
    end
  end

  // each cell shifts from a neighbor, loads the word or holds
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.ins) begin
        if (i == pos_i) begin
          entries[i] <= data;
        end else if (i > pos_i && i <= cnt_i) begin
          entries[i] <= below[i];
        end
      end else if (cmd.rem) begin
        if (i >= pos_i && i + 1 < cnt_i) begin
          entries[i] <= above[i];
        end
      end
    end
  end

  // read selector over the cells
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == pos_i) begin
        rd_word = entries[i];
      end
    end
  end

  // entry counter
  always_comb begin
    priority if (cmd.ins) begin
      count_next = count + COUNT_W'(1);
    end else if (cmd.rem) begin
      count_next = count - COUNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status    <= cmd.status;
      out_read_data <= cmd.rd_en ? rd_word : '0;
      out_count     <= count_next;
    end
  end

endmodule

### sv/indexed_list_insert_remove_unit.sv
// indexed_list_insert_remove_unit: ordered list with get, insert and remove
// result: valid in the cycle after its item is accepted
// throughput: one item per cycle while results are taken; the affected entry cells shift in the accept cycle
// a waiting result holds off the input; the next item enters as it is taken
// reset: entry count cleared, capacity set to 16; entry contents stay undefined
module indexed_list_insert_remove_unit
  import ilir_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,      // max_count
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // position [3:0], data [35:4], zero pad
  input  logic [OP_W-1:0]     s_axis_tuser,   // op [1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // read_data [31:0], count [36:32], zero pad
  output logic [STATUS_W-1:0] m_axis_tuser    // status [1:0]
);

  cmd_t                     cmd;
  logic [COUNT_W-1:0]       count;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data;
  status_t                  out_status;
  logic signed [DATA_W-1:0] out_read_data;
  logic [COUNT_W-1:0]       out_count;

  // unpack input item
  assign position = s_axis_tdata[POS_W-1:0];
  assign data     = s_axis_tdata[POS_W+DATA_W-1:POS_W];

  ilir_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .op        (s_axis_tuser),
    .position  (position),
    .count     (count),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  ilir_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .position      (position),
    .data          (data),
    .count         (count),
    .out_status    (out_status),
    .out_read_data (out_read_data),
    .out_count     (out_count)
  );

  // pack result item
  assign m_axis_tdata = {3'b000, out_count, out_read_data};
  assign m_axis_tuser = out_status;

endmodule
